@@ rtl/core/rbc_pkg.sv @@
// Shared constants and types for the red blob centroid block.
`timescale 1ns / 1ps

package rbc_pkg;

  localparam int CFG_W       = 11;
  localparam int COLOR_W     = 8;
  localparam int MEAN_W      = 14;
  localparam int FRAC_W      = 4;
  localparam int MEAN_MAX    = 16383;
  localparam int QUEUE_DEPTH = 4;

  localparam int DEF_MAX_WIDTH    = 1024;
  localparam int DEF_MAX_HEIGHT   = 1024;
  localparam int DEF_SIZE_DIVISOR = 20;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

  // configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [COLOR_W-1:0] COLOR_FULL = 8'd255;

  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_TARGET = 1'b1;

  // classified pixel handed from the front to the back
  typedef struct packed {
    logic               reddish;
    logic               frame_end;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rbc_pixel_t;

endpackage

@@ rtl/core/rbc_front.sv @@
// Front: classifies incoming pixels and tracks the raster position.
`timescale 1ns / 1ps

module rbc_front #(
  parameter int MAX_WIDTH  = rbc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rbc_pkg::DEF_MAX_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic [rbc_pkg::COLOR_W-1:0]        pixel_red,
  input  logic [rbc_pkg::COLOR_W-1:0]        pixel_green,
  input  logic [rbc_pkg::COLOR_W-1:0]        pixel_blue,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]     width_eff,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]    height_eff,
  output rbc_pkg::rbc_pixel_t                pixel,
  output logic [$clog2(MAX_WIDTH)-1:0]       column,
  output logic [$clog2(MAX_HEIGHT)-1:0]      row
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int HW = $clog2(MAX_HEIGHT+1);
  localparam int PW = rbc_pkg::COLOR_W + 3;

  logic [CW-1:0] column_counter;
  logic [RW-1:0] row_counter;
  logic [PW-1:0] red5, green5;
  logic          reddish, row_end, frame_end;

  always_comb begin
    red5      = (PW'(pixel_blue) << 2) + PW'(pixel_blue);
    green5    = (PW'(pixel_green) << 2) + PW'(pixel_green);
    reddish   = (PW'(pixel_red) > red5) && (PW'(pixel_red) > green5);
    row_end   = WW'(column_counter) >= (width_eff - WW'(1));
    frame_end = row_end && (HW'(row_counter) >= (height_eff - HW'(1)));
  end

  always_comb begin
    pixel.reddish   = reddish;
    pixel.frame_end = frame_end;
    pixel.red       = reddish ? rbc_pkg::COLOR_FULL : pixel_red;
    pixel.green     = pixel_green;
    pixel.blue      = pixel_blue;
    column          = column_counter;
    row             = row_counter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter <= '0;
      row_counter    <= '0;
    end else if (accept) begin
      if (frame_end) begin
        column_counter <= '0;
        row_counter    <= '0;
      end else if (row_end) begin
        column_counter <= '0;
        row_counter    <= row_counter + RW'(1);
      end else begin
        column_counter <= column_counter + CW'(1);
      end
    end
  end

endmodule

@@ rtl/core/rbc_queue.sv @@
// Short queue between the front and the back.
`timescale 1ns / 1ps

module rbc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rbc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [NW-1:0]    fill;

  assign full     = fill == NW'(DEPTH);
  assign empty    = fill == '0;
  assign pop_data = entries[rd_ptr];

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH-1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop)      fill <= fill + NW'(1);
      else if (pop && !push) fill <= fill - NW'(1);
    end
  end

endmodule

@@ rtl/core/rbc_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module rbc_div #(
  parameter int DW = 16,
  parameter int VW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int NW = $clog2(DW+1);

  logic [VW-1:0] rem;
  logic [VW-1:0] dvsr;
  logic [NW-1:0] steps;
  logic [VW:0]   shifted;
  logic          fits;

  always_comb begin
    shifted = {rem, quotient[DW-1]};
    fits    = shifted >= {1'b0, dvsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= NW'(DW);
      end else if (busy) begin
        steps <= steps - NW'(1);
        if (steps == NW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvsr     <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? VW'(shifted - {1'b0, dvsr}) : shifted[VW-1:0];
      quotient <= {quotient[DW-2:0], fits};
    end
  end

endmodule

@@ rtl/core/rbc_back.sv @@
// Back: accumulates reddish positions, emits pixel and frame target results.
`timescale 1ns / 1ps

module rbc_back #(
  parameter int MAX_WIDTH    = rbc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = rbc_pkg::DEF_MAX_HEIGHT,
  parameter int SIZE_DIVISOR = rbc_pkg::DEF_SIZE_DIVISOR
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_empty,
  input  rbc_pkg::rbc_pixel_t              q_pixel,
  input  logic [$clog2(MAX_WIDTH)-1:0]     q_column,
  input  logic [$clog2(MAX_HEIGHT)-1:0]    q_row,
  output logic                             q_pop,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]   width_eff,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]  height_eff,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             result_kind,
  output logic [rbc_pkg::COLOR_W-1:0]      out_red,
  output logic [rbc_pkg::COLOR_W-1:0]      out_green,
  output logic [rbc_pkg::COLOR_W-1:0]      out_blue,
  output logic [rbc_pkg::MEAN_W-1:0]       mean_column,
  output logic [rbc_pkg::MEAN_W-1:0]       mean_row,
  output logic                             target_found,
  output logic                             last_of_run
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH+1);
  localparam int HW    = $clog2(MAX_HEIGHT+1);
  localparam int NCW   = $clog2(MAX_WIDTH*MAX_HEIGHT+1);
  localparam int CSW   = CW + NCW;
  localparam int RSW   = RW + NCW;
  localparam int SUMW  = (CSW > RSW) ? CSW : RSW;
  localparam int DW    = SUMW + rbc_pkg::FRAC_W;
  localparam int VW    = NCW;
  localparam int LW    = WW + HW;
  localparam int MW    = rbc_pkg::MEAN_W;

  // size / SIZE_DIVISOR as (size * RM) >> RS, exact for every size below 2**XW
  localparam int XW    = (WW > HW) ? WW : HW;
  localparam int RS    = XW + $clog2(SIZE_DIVISOR);
  localparam longint unsigned RM =
    ((64'd1 << RS) + 64'(SIZE_DIVISOR) - 64'd1) / 64'(SIZE_DIVISOR);
  localparam int PRW   = XW + RS + 1;

  typedef enum logic [4:0] {
    ST_RUN   = 5'b00001,
    ST_START = 5'b00010,
    ST_WAIT  = 5'b00100,
    ST_LIMIT = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  typedef enum logic {
    OP_COL = 1'b0,
    OP_ROW = 1'b1
  } op_t;

  state_t         state;
  op_t            op;
  logic [CSW-1:0] column_sum;
  logic [RSW-1:0] row_sum;
  logic [NCW-1:0] reddish_count;
  logic [MW-1:0]  mean_col_r, mean_row_r;
  logic [WW-1:0]  width_q;
  logic [HW-1:0]  height_q;
  logic [LW-1:0]  limit;
  logic [PRW-1:0] width_prod, height_prod;

  logic           out_free;
  logic           div_start, div_busy, div_done;
  logic [DW-1:0]  div_dividend, div_q;
  logic [VW-1:0]  div_divisor;
  logic [MW-1:0]  q_sat;

  assign out_free  = !out_valid || out_ready;
  assign q_pop     = (state == ST_RUN) && !q_empty && out_free;
  assign div_start = state == ST_START;

  always_comb begin
    case (op)
      OP_COL:  div_dividend = DW'({column_sum, {rbc_pkg::FRAC_W{1'b0}}});
      OP_ROW:  div_dividend = DW'({row_sum, {rbc_pkg::FRAC_W{1'b0}}});
      default: div_dividend = '0;
    endcase
    div_divisor = VW'(reddish_count);
    if (reddish_count == '0)
      q_sat = '0;
    else if (div_q > DW'(rbc_pkg::MEAN_MAX))
      q_sat = MW'(rbc_pkg::MEAN_MAX);
    else
      q_sat = div_q[MW-1:0];
    width_prod  = PRW'(width_eff) * PRW'(RM);
    height_prod = PRW'(height_eff) * PRW'(RM);
  end

  rbc_div #(
    .DW(DW),
    .VW(VW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_RUN;
      op            <= OP_COL;
      out_valid     <= 1'b0;
      column_sum    <= '0;
      row_sum       <= '0;
      reddish_count <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_RUN: begin
          if (q_pop) begin
            if (q_pixel.reddish) begin
              column_sum    <= column_sum + CSW'(q_column);
              row_sum       <= row_sum + RSW'(q_row);
              reddish_count <= reddish_count + NCW'(1);
            end
            out_valid <= 1'b1;
            if (q_pixel.frame_end) begin
              state <= ST_START;
              op    <= OP_COL;
            end
          end
        end
        ST_START: state <= ST_WAIT;
        ST_WAIT: begin
          if (div_done) begin
            if (op == OP_ROW) state <= ST_LIMIT;
            else begin
              op    <= OP_ROW;
              state <= ST_START;
            end
          end
        end
        ST_LIMIT: state <= ST_EMIT;
        ST_EMIT: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            column_sum    <= '0;
            row_sum       <= '0;
            reddish_count <= '0;
            state         <= ST_RUN;
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

  // result payload and division results
  always_ff @(posedge clk) begin
    if (q_pop) begin
      result_kind  <= rbc_pkg::KIND_PIXEL;
      out_red      <= q_pixel.red;
      out_green    <= q_pixel.green;
      out_blue     <= q_pixel.blue;
      mean_column  <= '0;
      mean_row     <= '0;
      target_found <= 1'b0;
      last_of_run  <= !q_pixel.frame_end;
    end else if (state == ST_EMIT && out_free) begin
      result_kind  <= rbc_pkg::KIND_TARGET;
      out_red      <= '0;
      out_green    <= '0;
      out_blue     <= '0;
      mean_column  <= mean_col_r;
      mean_row     <= mean_row_r;
      target_found <= LW'(reddish_count) > limit;
      last_of_run  <= 1'b1;
    end
    if (state == ST_WAIT && div_done) begin
      case (op)
        OP_COL:  mean_col_r <= q_sat;
        OP_ROW:  mean_row_r <= q_sat;
        default: ;
      endcase
    end
    if (state == ST_START) begin
      width_q  <= WW'(width_prod >> RS);
      height_q <= HW'(height_prod >> RS);
    end
    if (state == ST_LIMIT) limit <= LW'(width_q) * LW'(height_q);
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_sums_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WAIT) |=> $stable(reddish_count) && $stable(column_sum))
    else $error("accumulators changed during division");

  a_frame_end_seq: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_pixel.frame_end) |=> (state == ST_START) && out_valid && !last_of_run)
    else $error("frame end did not start the target sequence");

  a_target_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_free) |=> out_valid && result_kind && last_of_run)
    else $error("target result not issued");

endmodule

@@ rtl/core/red_blob_centroid_top.sv @@
// Top level of the red blob centroid block.
`timescale 1ns / 1ps
//
// Pixels enter on in_valid/in_ready in raster order (pixel_red/green/blue).
// Each pixel yields one result on out_valid/out_ready: the pixel itself, red
// forced to 255 when red exceeds five times green and five times blue. After
// the last pixel of a frame a second, target result follows with the mean
// column and row of the reddish pixels (4 fraction bits) and a found flag.
// Frame size is set through cfg_we/cfg_index/cfg_data (0 width, 1 height);
// the user must do so only while the block is idle; the block does not check.
// With the queue empty and the output free, an accepted pixel is first written
// into the queue, then popped by the back into the output register.
// Throughput: one pixel per cycle inside a frame while out_ready stays high.
// At frame end the back runs two divisions, column then row, on its bit-serial
// divider (DW = 35 at the default 1024x1024 maximum), then forms the limit;
// the 4-entry queue fills and in_ready drops until the target result is loaded.
// Reset clears position, sums and queue; size registers return to 640x480.
// A stalled receiver holds the output register; the queue keeps taking
// pixels until it is full.

module red_blob_centroid_top #(
  parameter int MAX_WIDTH    = rbc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = rbc_pkg::DEF_MAX_HEIGHT,
  parameter int SIZE_DIVISOR = rbc_pkg::DEF_SIZE_DIVISOR
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [rbc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rbc_pkg::COLOR_W-1:0]   pixel_red,
  input  logic [rbc_pkg::COLOR_W-1:0]   pixel_green,
  input  logic [rbc_pkg::COLOR_W-1:0]   pixel_blue,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          result_kind,
  output logic [rbc_pkg::COLOR_W-1:0]   out_red,
  output logic [rbc_pkg::COLOR_W-1:0]   out_green,
  output logic [rbc_pkg::COLOR_W-1:0]   out_blue,
  output logic [rbc_pkg::MEAN_W-1:0]    mean_column,
  output logic [rbc_pkg::MEAN_W-1:0]    mean_row,
  output logic                          target_found,
  output logic                          last_of_run
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int HW = $clog2(MAX_HEIGHT+1);
  localparam int PXW = $bits(rbc_pkg::rbc_pixel_t);
  localparam int EW = PXW + CW + RW;

  logic [rbc_pkg::CFG_W-1:0] frame_width, frame_height;
  logic [WW-1:0]             width_eff;
  logic [HW-1:0]             height_eff;

  rbc_pkg::rbc_pixel_t       f_pixel, q_pixel;
  logic [CW-1:0]             f_column, q_column;
  logic [RW-1:0]             f_row, q_row;
  logic [EW-1:0]             q_data;
  logic                      accept, q_full, q_empty, q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= rbc_pkg::WIDTH_RESET;
      frame_height <= rbc_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rbc_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        rbc_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize as the maximum
  always_comb begin
    if (frame_width == '0)
      width_eff = WW'(1);
    else if (32'(frame_width) > 32'(MAX_WIDTH))
      width_eff = WW'(MAX_WIDTH);
    else
      width_eff = WW'(frame_width);
    if (frame_height == '0)
      height_eff = HW'(1);
    else if (32'(frame_height) > 32'(MAX_HEIGHT))
      height_eff = HW'(MAX_HEIGHT);
    else
      height_eff = HW'(frame_height);
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  rbc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .pixel_red   (pixel_red),
    .pixel_green (pixel_green),
    .pixel_blue  (pixel_blue),
    .width_eff   (width_eff),
    .height_eff  (height_eff),
    .pixel       (f_pixel),
    .column      (f_column),
    .row         (f_row)
  );

  rbc_queue #(
    .WIDTH (EW),
    .DEPTH (rbc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data ({f_pixel, f_column, f_row}),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign q_pixel  = q_data[EW-1 -: PXW];
  assign q_column = q_data[CW+RW-1 -: CW];
  assign q_row    = q_data[RW-1:0];

  rbc_back #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .SIZE_DIVISOR (SIZE_DIVISOR)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_pixel      (q_pixel),
    .q_column     (q_column),
    .q_row        (q_row),
    .q_pop        (q_pop),
    .width_eff    (width_eff),
    .height_eff   (height_eff),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .mean_column  (mean_column),
    .mean_row     (mean_row),
    .target_found (target_found),
    .last_of_run  (last_of_run)
  );

endmodule
